[design/dzm_pkg.sv]
`default_nettype none

package dzm_pkg;

  // Sizing
  localparam int MAX_VERTICES = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MIN_VERTICES = 3;

  localparam int IN_W     = 19;                       // signed Q2.16 input fields
  localparam int COORD_W  = 17;                       // unsigned Q1.16 coordinates
  localparam int CTR_W    = IN_W + 2;                 // 2*pos + size
  localparam int DIFF_W   = COORD_W + 1;              // signed coordinate difference
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int BAND_W   = COORD_W + 3;              // 5 * coordinate
  localparam int IDX_W    = 4;                        // vertex_index field
  localparam int VCNT_W   = 5;                        // vertex_count register
  localparam int AW       = $clog2(MAX_VERTICES);
  localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam longint unsigned ONE_FX = 64'd1 << FRAC_BITS;
  localparam longint unsigned EPS_FX =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd50000000) / 64'd100000000;

  localparam logic [COORD_W-1:0] ONE_C      = COORD_W'(ONE_FX);
  localparam logic [COORD_W-1:0] QUARTER_C  = COORD_W'(ONE_FX / 4);
  localparam logic [COORD_W-1:0] THREE_Q_C  = COORD_W'((3 * ONE_FX) / 4);
  localparam logic [BAND_W-1:0]  BAND_LO_C  = BAND_W'(2 * ONE_FX);
  localparam logic [BAND_W-1:0]  BAND_HI_C  = BAND_W'(3 * ONE_FX);

  // Codes
  typedef enum logic [2:0] {
    ZM_FULL   = 3'd0,
    ZM_CENTER = 3'd1,
    ZM_LEFT   = 3'd2,
    ZM_RIGHT  = 3'd3,
    ZM_TOP    = 3'd4,
    ZM_BOTTOM = 3'd5,
    ZM_CUSTOM = 3'd6
  } zone_mode_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE_MODE    = 2'd0,
    REG_VERTEX_COUNT = 2'd1
  } reg_idx_e;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // One edge a->b handed to the edge unit
  typedef struct packed {
    logic    valid;
    logic    last;
    vertex_t a;
    vertex_t b;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic on_edge;
    logic toggle;
  } edge_res_t;

  // Clamp a signed value to [0, ONE]
  function automatic coord_t clamp_unit(input logic signed [CTR_W-1:0] v);
    coord_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({1'b0, CTR_W'(ONE_FX)})) begin
      r = ONE_C;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/dzm_in_if.sv]
`default_nettype none

interface dzm_in_if import dzm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [IN_W-1:0]  vertex_x;
  logic signed [IN_W-1:0]  vertex_y;
  logic signed [IN_W-1:0]  box_x;
  logic signed [IN_W-1:0]  box_y;
  logic signed [IN_W-1:0]  box_w;
  logic signed [IN_W-1:0]  box_h;

  modport source (
    output valid, cmd, vertex_index, vertex_x, vertex_y, box_x, box_y, box_w, box_h,
    input  ready
  );
  modport sink (
    input  valid, cmd, vertex_index, vertex_x, vertex_y, box_x, box_y, box_w, box_h,
    output ready
  );
endinterface

`default_nettype wire

[design/dzm_out_if.sv]
`default_nettype none

interface dzm_out_if import dzm_pkg::*; ();
  logic         valid;
  logic         ready;
  logic         zone_match;
  coord_t       center_x;
  coord_t       center_y;

  modport source (output valid, zone_match, center_x, center_y, input ready);
  modport sink   (input valid, zone_match, center_x, center_y, output ready);
endinterface

`default_nettype wire

[design/dzm_cfg_if.sv]
`default_nettype none

interface dzm_cfg_if import dzm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/dzm_vtx_mem.sv]
`default_nettype none

module dzm_vtx_mem import dzm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire vertex_t       wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output vertex_t            rdata_o
);

  vertex_t mem_q [MAX_VERTICES];
  vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/dzm_edge_unit.sv]
`default_nettype none

// Three-stage edge evaluator: differences, products, sums. Flags come out
// of the last stage; one edge may enter every cycle.
module dzm_edge_unit import dzm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire coord_t    px_i,
  input  wire coord_t    py_i,
  input  wire edge_req_t req_i,
  output edge_res_t      res_o
);

  localparam logic signed [SUM_W-1:0] EPS_S = SUM_W'(EPS_FX);

  // stage 1: differences
  logic                     s1_vld_q, s1_last_q;
  logic signed [DIFF_W-1:0] ex_q, ey_q, qx_q, qy_q;
  logic                     s1_strad_q;
  // stage 2: products
  logic                     s2_vld_q, s2_last_q;
  logic signed [PROD_W-1:0] p_qyex_q, p_qxey_q, p_qxex_q, p_qyey_q, p_exex_q, p_eyey_q;
  logic                     s2_strad_q, s2_eypos_q;
  // stage 3: sums
  logic                     s3_vld_q, s3_last_q;
  logic signed [SUM_W-1:0]  cr_q, dt_q, len_q;
  logic                     s3_strad_q, s3_eypos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      s3_vld_q  <= 1'b0;
      s3_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= req_i.valid;
      s1_last_q <= req_i.valid && req_i.last;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      s3_vld_q  <= s2_vld_q;
      s3_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ex_q <= $signed({1'b0, req_i.b.x}) - $signed({1'b0, req_i.a.x});
    ey_q <= $signed({1'b0, req_i.b.y}) - $signed({1'b0, req_i.a.y});
    qx_q <= $signed({1'b0, px_i}) - $signed({1'b0, req_i.a.x});
    qy_q <= $signed({1'b0, py_i}) - $signed({1'b0, req_i.a.y});
    s1_strad_q <= (req_i.a.y > py_i) != (req_i.b.y > py_i);

    p_qyex_q <= qy_q * ex_q;
    p_qxey_q <= qx_q * ey_q;
    p_qxex_q <= qx_q * ex_q;
    p_qyey_q <= qy_q * ey_q;
    p_exex_q <= ex_q * ex_q;
    p_eyey_q <= ey_q * ey_q;
    s2_strad_q <= s1_strad_q;
    s2_eypos_q <= ey_q > 0;

    // cross = rhs - lhs of the ray compare as well
    cr_q  <= SUM_W'(p_qyex_q) - SUM_W'(p_qxey_q);
    dt_q  <= SUM_W'(p_qxex_q) + SUM_W'(p_qyey_q);
    len_q <= SUM_W'(p_exex_q) + SUM_W'(p_eyey_q);
    s3_strad_q <= s2_strad_q;
    s3_eypos_q <= s2_eypos_q;
  end

  always_comb begin
    res_o.valid   = s3_vld_q;
    res_o.last    = s3_last_q;
    res_o.on_edge = (cr_q <= EPS_S) && (cr_q >= -EPS_S) &&
                    (dt_q >= -EPS_S) && (dt_q <= len_q + EPS_S);
    res_o.toggle  = s3_strad_q && (s3_eypos_q ? (cr_q > 0) : (cr_q < 0));
  end

endmodule

`default_nettype wire

[design/detection_zone_matcher.sv]
// Channel   Dir  Handshake      Word
// in_i      in   valid/ready    cmd, vertex_index, vertex_x/y, box_x/y/w/h
// out_o     out  valid/ready    zone_match, center_x, center_y
// cfg_i     in   valid/ready    index (0 zone_mode, 1 vertex_count), data
//
// Load words are accepted back to back.
// Preset zone tests, and custom tests with fewer than three vertices, go from idle
// straight to the finish state, which loads the result word and returns to idle.
// Custom polygon tests: n + 1 table reads, one per cycle (n = vertex count saturated
// to 16), feed one shared three-stage edge unit, then the parity is closed and the
// finish state loads the result word. Reset is asynchronous, active low; the vertex
// table is not cleared. A result word waiting on out_o holds the next test in its
// last state, and the input with it, until the word is taken.
`default_nettype none

module detection_zone_matcher import dzm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dzm_in_if.sink    in_i,
  dzm_out_if.source out_o,
  dzm_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e st_q, st_d;

  // Configuration
  logic [2:0]        mode_q;
  logic [VCNT_W-1:0] count_q;
  logic [CNT_W-1:0]  n;
  logic              poly_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ZM_FULL;
      count_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ZONE_MODE:    mode_q  <= cfg_i.data[2:0];
        REG_VERTEX_COUNT: count_q <= cfg_i.data[VCNT_W-1:0];
        default:          ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Saturate the vertex count to the table depth
  always_comb begin
    if (int'(count_q) > MAX_VERTICES) begin
      n = CNT_W'(MAX_VERTICES);
    end else begin
      n = CNT_W'(count_q);
    end
    poly_ok = int'(n) >= MIN_VERTICES;
  end

  // Input acceptance
  logic in_acc, is_load, is_test;
  assign in_i.ready = (st_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_load    = in_acc && (in_i.cmd == CMD_LOAD);
  assign is_test    = in_acc && (in_i.cmd == CMD_TEST);

  // Box center: floor((2*pos + size) / 2), clamped to [0, ONE]
  logic signed [CTR_W-1:0] sum_x, sum_y;
  coord_t cx_d, cy_d, cx_q, cy_q;

  always_comb begin
    sum_x = (CTR_W'(in_i.box_x) <<< 1) + CTR_W'(in_i.box_w);
    sum_y = (CTR_W'(in_i.box_y) <<< 1) + CTR_W'(in_i.box_h);
    cx_d  = clamp_unit(sum_x >>> 1);
    cy_d  = clamp_unit(sum_y >>> 1);
  end

  always_ff @(posedge clk_i) begin
    if (is_test) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  // Vertex table: loads write clamped vertices, the scan reads them
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  vertex_t         mem_wdata, mem_rdata;

  assign mem_we          = is_load && (int'(in_i.vertex_index) < MAX_VERTICES);
  assign mem_waddr       = AW'(in_i.vertex_index);
  assign mem_wdata.x     = clamp_unit(CTR_W'(in_i.vertex_x));
  assign mem_wdata.y     = clamp_unit(CTR_W'(in_i.vertex_y));

  dzm_vtx_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Scan sequencer: read vertex n-1 first, then 0 .. n-1, so that each
  // read after the first closes one edge with the vertex before it.
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             scan_end;

  assign scan_end  = (cnt_q == n);
  assign mem_raddr = (cnt_q == '0) ? AW'(n - CNT_W'(1)) : AW'(cnt_q - CNT_W'(1));

  // Read return tracking
  logic    rd_vld_q, rd_last_q, first_q;
  vertex_t prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      rd_vld_q  <= (st_q == ST_SCAN);
      rd_last_q <= (st_q == ST_SCAN) && scan_end;
      if (is_test) begin
        first_q <= 1'b1;
      end else if (rd_vld_q) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prev_q <= mem_rdata;
    end
  end

  // Shared edge unit
  edge_req_t edge_req;
  edge_res_t edge_res;

  always_comb begin
    edge_req.valid = rd_vld_q && !first_q;
    edge_req.last  = rd_last_q;
    edge_req.a     = prev_q;
    edge_req.b     = mem_rdata;
  end

  dzm_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .px_i   (cx_q),
    .py_i   (cy_q),
    .req_i  (edge_req),
    .res_o  (edge_res)
  );

  // Even-odd parity and on-edge hit over all edges
  logic inside_q, hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (is_test) begin
      inside_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (edge_res.valid) begin
      inside_q <= inside_q ^ edge_res.toggle;
      hit_q    <= hit_q | edge_res.on_edge;
    end
  end

  // Zone decision from the stored center
  logic [BAND_W-1:0] cx5, cy5;
  logic              match;

  always_comb begin
    cx5 = (BAND_W'(cx_q) << 2) + BAND_W'(cx_q);
    cy5 = (BAND_W'(cy_q) << 2) + BAND_W'(cy_q);
    case (mode_q)
      ZM_FULL:   match = 1'b1;
      ZM_CENTER: match = (cx_q >= QUARTER_C) && (cx_q <= THREE_Q_C) &&
                         (cy_q >= QUARTER_C) && (cy_q <= THREE_Q_C);
      ZM_LEFT:   match = cx5 <= BAND_LO_C;
      ZM_RIGHT:  match = cx5 >= BAND_HI_C;
      ZM_TOP:    match = cy5 <= BAND_LO_C;
      ZM_BOTTOM: match = cy5 >= BAND_HI_C;
      ZM_CUSTOM: match = poly_ok && (hit_q || inside_q);
      default:   match = 1'b1;
    endcase
  end

  // Output register: hold the word until taken
  logic   out_vld_q, out_free, out_load;
  logic   out_match_q;
  coord_t out_cx_q, out_cy_q;

  assign out_free = !out_vld_q || out_o.ready;
  assign out_load = (st_q == ST_FINISH) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_match_q <= match;
      out_cx_q    <= cx_q;
      out_cy_q    <= cy_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.zone_match = out_match_q;
  assign out_o.center_x   = out_cx_q;
  assign out_o.center_y   = out_cy_q;

  // Sequencer
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    case (st_q)
      ST_IDLE: begin
        if (is_test) begin
          cnt_d = '0;
          if ((mode_q == ZM_CUSTOM) && poly_ok) begin
            st_d = ST_SCAN;
          end else begin
            st_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (scan_end) begin
          st_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // advance once the last edge leaves the unit
        if (edge_res.valid && edge_res.last) begin
          st_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[design/dzm_checker.sv]
`default_nettype none

module dzm_checker import dzm_pkg::*; (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   in_valid,
  input wire logic   in_ready,
  input wire logic   in_cmd,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire logic   out_match,
  input wire coord_t out_cx,
  input wire coord_t out_cy
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_match) && $stable(out_cx) && $stable(out_cy))
    else $error("result word changed while stalled");

  // A taken test word makes the block busy and drops input ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_cmd == CMD_TEST) |=> !in_ready)
    else $error("input taken right after a test word");

  // Loads never stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_cmd == CMD_LOAD) |=> in_ready)
    else $error("input stalled after a load word");

endmodule

bind detection_zone_matcher dzm_checker u_dzm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_cmd    (in_i.cmd),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_match (out_o.zone_match),
  .out_cx    (out_o.center_x),
  .out_cy    (out_o.center_y)
);

`default_nettype wire

[sim/tb_detection_zone_matcher.sv]
module tb_detection_zone_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import dzm_pkg::*;

  localparam realtime CLK_HALF    = 2ns;
  localparam int      RESET_CYC   = 6;
  localparam int      SETTLE_CYC  = 32;    // outlasts the longest custom test holding the input
  localparam int      STALL_LIMIT = 2000;  // cycles with no word moving on any channel
  localparam int      RAND_WORDS  = 1550;
  localparam int      PRINT_CAP   = 50;

  // Mode 7 is outside the enum; the block treats it like full frame.
  localparam logic [2:0] ZM_UNKNOWN = 3'd7;

  localparam longint UNIT     = longint'(ONE_FX);
  localparam longint QUARTER  = UNIT / 4;
  localparam longint THREE_Q  = (3 * UNIT) / 4;
  localparam longint EDGE_TOL = longint'(EPS_FX);

  // Center coordinates that sit right on or next to a preset zone limit.
  localparam longint BAND_EDGES [12] = '{0, 16383, 16384, 16385, 26214, 26215,
                                         39321, 39322, 49151, 49152, 49153, 65536};

  // Zone mode per random phase; custom gets the most phases.
  localparam logic [2:0] PHASE_MODES [11] = '{ZM_CUSTOM, ZM_FULL, ZM_CUSTOM, ZM_CENTER,
                                              ZM_LEFT, ZM_CUSTOM, ZM_RIGHT, ZM_TOP,
                                              ZM_CUSTOM, ZM_BOTTOM, ZM_UNKNOWN};

  typedef struct {
    cmd_e                   cmd;
    logic [IDX_W-1:0]       slot;
    logic signed [IN_W-1:0] vx;
    logic signed [IN_W-1:0] vy;
    logic signed [IN_W-1:0] bx;
    logic signed [IN_W-1:0] by;
    logic signed [IN_W-1:0] bw;
    logic signed [IN_W-1:0] bh;
  } in_word_t;

  typedef struct {
    logic   hit;
    coord_t cx;
    coord_t cy;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dzm_in_if  in_if ();
  dzm_out_if out_if ();
  dzm_cfg_if cfg_if ();

  detection_zone_matcher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Predictor state: zone registers and the vertex tables as the block holds them.
  logic [2:0]        mode_m;
  logic [VCNT_W-1:0] vcount_m;
  coord_t            poly_x [MAX_VERTICES];
  coord_t            poly_y [MAX_VERTICES];

  // Vertex tables as they will be once every queued word is in; used to aim
  // test points at vertices and edges.
  longint plan_x [MAX_VERTICES];
  longint plan_y [MAX_VERTICES];

  in_word_t pending_words [$];
  verdict_t due_verdicts [$];
  in_word_t cur_word;
  verdict_t want_v;

  bit no_idle;
  int gap_cnt;
  int stall_cnt;
  int idle_cycles;
  int mismatches;
  int words_sent;
  int tests_sent;
  int verdicts_checked;
  int cfg_writes;
  int phases_run;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_to_unit(longint v);
    if (v < 0) return 0;
    if (v > UNIT) return UNIT;
    return v;
  endfunction

  // Point p lies on segment a-b within the edge tolerance.
  function automatic bit touches_edge(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by);
    longint ex, ey, qx, qy, cr, dt;
    ex = bx - ax;
    ey = by - ay;
    qx = px - ax;
    qy = py - ay;
    cr = qy * ex - qx * ey;
    if (cr > EDGE_TOL || cr < -EDGE_TOL) return 1'b0;
    dt = qx * ex + qy * ey;
    if (dt < -EDGE_TOL) return 1'b0;
    return dt <= ex * ex + ey * ey + EDGE_TOL;
  endfunction

  // Even-odd ray casting over the first n table entries; an edge hit wins.
  function automatic bit point_in_poly(longint px, longint py, int n);
    bit     odd;
    int     j;
    longint ax, ay, bx, by, d, lhs, rhs;
    bit     flip;
    odd = 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      ax = poly_x[j];
      ay = poly_y[j];
      bx = poly_x[i];
      by = poly_y[i];
      if (touches_edge(px, py, ax, ay, bx, by)) return 1'b1;
      if ((ay > py) != (by > py)) begin
        d   = by - ay;
        lhs = (px - ax) * d;
        rhs = (bx - ax) * (py - ay);
        // The compare direction follows the sign of the edge's y extent.
        flip = (d > 0) ? (lhs < rhs) : (lhs > rhs);
        if (flip) odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic verdict_t zone_verdict(in_word_t w);
    verdict_t r;
    longint   cx, cy;
    int       n;
    // Center is floor((2*pos + size) / 2), then clamped to the frame.
    cx = clamp_to_unit((2 * longint'(w.bx) + longint'(w.bw)) >>> 1);
    cy = clamp_to_unit((2 * longint'(w.by) + longint'(w.bh)) >>> 1);
    case (mode_m)
      ZM_CENTER: r.hit = cx >= QUARTER && cx <= THREE_Q && cy >= QUARTER && cy <= THREE_Q;
      ZM_LEFT:   r.hit = 5 * cx <= 2 * UNIT;
      ZM_RIGHT:  r.hit = 5 * cx >= 3 * UNIT;
      ZM_TOP:    r.hit = 5 * cy <= 2 * UNIT;
      ZM_BOTTOM: r.hit = 5 * cy >= 3 * UNIT;
      ZM_CUSTOM: begin
        n = (vcount_m > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_m);
        r.hit = (n >= MIN_VERTICES) && point_in_poly(cx, cy, n);
      end
      default:   r.hit = 1'b1;
    endcase
    r.cx = coord_t'(cx);
    r.cy = coord_t'(cy);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [IN_W-1:0] rand_in();
    return IN_W'($urandom);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Vertex coordinate: coarse grid so edges line up, any in-frame value, or raw noise.
  function automatic logic signed [IN_W-1:0] vertex_raw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return IN_W'($urandom_range(0, 16) * 4096);
    if (r < 85) return IN_W'($urandom_range(0, 65536));
    return rand_in();
  endfunction

  task automatic push_load(int slot, logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y);
    in_word_t w;
    w.cmd  = CMD_LOAD;
    w.slot = IDX_W'(slot);
    w.vx   = x;
    w.vy   = y;
    w.bx   = rand_in();
    w.by   = rand_in();
    w.bw   = rand_in();
    w.bh   = rand_in();
    plan_x[slot] = clamp_to_unit(longint'(x));
    plan_y[slot] = clamp_to_unit(longint'(y));
    pending_words.push_back(w);
  endtask

  task automatic push_box(logic signed [IN_W-1:0] bx, logic signed [IN_W-1:0] by,
                          logic signed [IN_W-1:0] bw, logic signed [IN_W-1:0] bh);
    in_word_t w;
    w.cmd  = CMD_TEST;
    w.slot = IDX_W'($urandom);
    w.vx   = rand_in();
    w.vy   = rand_in();
    w.bx   = bx;
    w.by   = by;
    w.bw   = bw;
    w.bh   = bh;
    pending_words.push_back(w);
  endtask

  // Build a box of random size whose floored center lands exactly on (cx, cy).
  task automatic push_center(longint cx, longint cy);
    longint bw, bh, bx, by;
    if ($urandom_range(0, 1)) bw = longint'($urandom_range(0, 8192));
    else bw = longint'(rand_in());
    if ($urandom_range(0, 1)) bh = longint'($urandom_range(0, 8192));
    else bh = longint'(rand_in());
    // Match the parity of 2*pos + size to the size so the halving is exact.
    bx = (2 * cx + (bw & 1) - bw) / 2;
    by = (2 * cy + (bh & 1) - bh) / 2;
    push_box(IN_W'(bx), IN_W'(by), IN_W'(bw), IN_W'(bh));
  endtask

  // Aim a test point at a vertex, an edge midpoint, a zone limit, the grid or anywhere.
  task automatic push_aimed_test(int n);
    int     r, k, k2;
    longint cx, cy;
    r  = $urandom_range(0, 99);
    k  = $urandom_range(0, n - 1);
    k2 = (k + 1) % n;
    if (r < 25) begin
      cx = plan_x[k];
      cy = plan_y[k];
    end else if (r < 45) begin
      cx = (plan_x[k] + plan_x[k2]) >>> 1;
      cy = (plan_y[k] + plan_y[k2]) >>> 1;
    end else if (r < 60) begin
      cx = BAND_EDGES[$urandom_range(0, 11)];
      cy = BAND_EDGES[$urandom_range(0, 11)];
    end else if (r < 75) begin
      cx = longint'($urandom_range(0, 16) * 4096);
      cy = longint'($urandom_range(0, 16) * 4096);
    end else begin
      cx = longint'($urandom_range(0, 65536));
      cy = longint'($urandom_range(0, 65536));
    end
    push_center(cx, cy);
  endtask

  // Write one zone register and mirror it once the word is taken.
  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_ZONE_MODE) mode_m = val[2:0];
    else vcount_m = val[VCNT_W-1:0];
    cfg_writes++;
  endtask

  task automatic set_zone(logic [2:0] mode, logic [VCNT_W-1:0] vcount);
    write_reg(REG_ZONE_MODE, CFG_DATA_W'(mode));
    write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(vcount));
  endtask

  // Hold the sender until every queued word is in and every verdict is back,
  // then let the block settle so a trailing load cannot race a register write.
  task automatic drain();
    while (pending_words.size() != 0 || in_if.valid || due_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: pop the next word, hold it until taken, then idle a while.
  // Predict at the accepting edge so table and register state follow word order.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        words_sent++;
        if (cur_word.cmd == CMD_TEST) begin
          due_verdicts.push_back(zone_verdict(cur_word));
          tests_sent++;
        end else begin
          poly_x[cur_word.slot] = coord_t'(clamp_to_unit(longint'(cur_word.vx)));
          poly_y[cur_word.slot] = coord_t'(clamp_to_unit(longint'(cur_word.vy)));
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          in_if.valid        <= 1'b1;
          in_if.cmd          <= cur_word.cmd;
          in_if.vertex_index <= cur_word.slot;
          in_if.vertex_x     <= cur_word.vx;
          in_if.vertex_y     <= cur_word.vy;
          in_if.box_x        <= cur_word.bx;
          in_if.box_y        <= cur_word.by;
          in_if.box_w        <= cur_word.bw;
          in_if.box_h        <= cur_word.bh;
          gap_cnt = no_idle ? 0 : idle_len();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure: drop ready for random stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_cnt = 0;
    end else if (stall_cnt != 0) begin
      out_if.ready <= 1'b0;
      stall_cnt--;
    end else begin
      out_if.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 25) stall_cnt = idle_len();
    end
  end

  // Result monitor: check every taken word against the oldest verdict due.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_verdicts.size() == 0) begin
        report_mismatch($sformatf("result word with no test pending (match %0b, center %0d,%0d)",
                                  out_if.zone_match, out_if.center_x, out_if.center_y));
      end else begin
        want_v = due_verdicts.pop_front();
        if (out_if.zone_match !== want_v.hit)
          report_mismatch($sformatf("result %0d zone_match got %0b want %0b",
                                    verdicts_checked, out_if.zone_match, want_v.hit));
        if (out_if.center_x !== want_v.cx)
          report_mismatch($sformatf("result %0d center_x got %0d want %0d",
                                    verdicts_checked, out_if.center_x, want_v.cx));
        if (out_if.center_y !== want_v.cy)
          report_mismatch($sformatf("result %0d center_y got %0d want %0d",
                                    verdicts_checked, out_if.center_y, want_v.cy));
      end
      verdicts_checked++;
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("[%0t] watchdog: no traffic for %0d cycles", $realtime, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int       rand_words;
    int       n_words;
    int       r;
    int       ph;
    logic [2:0]        mode;
    logic [VCNT_W-1:0] vcount;

    // Put every block input at a known value before the first edge.
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_LOAD;
    in_if.vertex_index = '0;
    in_if.vertex_x     = '0;
    in_if.vertex_y     = '0;
    in_if.box_x        = '0;
    in_if.box_y        = '0;
    in_if.box_w        = '0;
    in_if.box_h        = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_ZONE_MODE;
    cfg_if.data        = '0;
    no_idle            = 1'b0;
    idle_cycles        = 0;
    mode_m             = ZM_FULL;
    vcount_m           = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      poly_x[i] = '0;
      poly_y[i] = '0;
      plan_x[i] = 0;
      plan_y[i] = 0;
    end

    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- Directed part ---
    // Only slots 0..3 get written here, so vertex counts stay at four or below.
    set_zone(ZM_FULL, 0);
    // Clamp both ways on load: triangle (0,0) (1,0) (0,1) plus a notch at (.25,.25).
    push_load(0, -262144, -262144);
    push_load(1, 262143, -1);
    push_load(2, 0, 262143);
    push_load(3, 16384, 16384);
    // Box field extremes, and an odd negative sum that floors below zero.
    push_box(262143, 262143, 262143, 262143);
    push_box(-262144, -262144, -262144, -262144);
    push_box(100, -5, -1, 3);
    drain();

    set_zone(ZM_CENTER, 0);
    push_center(16384, 49152);
    push_center(16383, 32768);
    drain();
    set_zone(ZM_LEFT, 0);
    push_center(26214, 0);
    push_center(26215, 0);
    drain();
    set_zone(ZM_RIGHT, 0);
    push_center(39321, 65536);
    push_center(39322, 65536);
    drain();
    set_zone(ZM_TOP, 0);
    push_center(0, 26214);
    push_center(0, 26215);
    drain();
    set_zone(ZM_BOTTOM, 0);
    push_center(65536, 39321);
    push_center(65536, 39322);
    drain();
    // Unknown mode falls back to full frame.
    set_zone(ZM_UNKNOWN, 0);
    push_center(65536, 0);
    drain();
    // Too few vertices: no match even on a vertex.
    set_zone(ZM_CUSTOM, 2);
    push_center(0, 0);
    drain();
    // Triangle: point on the hypotenuse, on a vertex, outside, inside.
    set_zone(ZM_CUSTOM, 3);
    push_center(32768, 32768);
    push_center(0, 0);
    push_center(40000, 40000);
    push_center(1000, 1000);
    drain();
    // Concave shape: notch vertex and two points inside.
    set_zone(ZM_CUSTOM, 4);
    push_center(16384, 16384);
    push_center(30000, 30000);
    push_center(8000, 4000);
    drain();

    // --- Random part ---
    // Fill the whole table first so any vertex count reads written entries only.
    for (int s = 0; s < MAX_VERTICES; s++) push_load(s, vertex_raw(), vertex_raw());
    rand_words = MAX_VERTICES;
    drain();

    ph = 0;
    while (rand_words < RAND_WORDS) begin
      mode = PHASE_MODES[ph % 11];
      r = $urandom_range(0, 99);
      if (ph == 0) vcount = VCNT_W'(31);              // saturates to the table size
      else if (mode != ZM_CUSTOM) vcount = VCNT_W'($urandom);
      else if (r < 12) vcount = VCNT_W'($urandom_range(0, 2));
      else if (r < 24) vcount = VCNT_W'($urandom_range(17, 31));
      else if (r < 36) vcount = VCNT_W'(MAX_VERTICES);
      else vcount = VCNT_W'($urandom_range(3, 15));
      set_zone(mode, vcount);
      no_idle = (ph % 4 == 2);

      n_words = $urandom_range(90, 150);
      for (int k = 0; k < n_words; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) push_load($urandom_range(0, 15), rand_in(), rand_in());
        else if (r < 8) push_box(rand_in(), rand_in(), rand_in(), rand_in());
        else if (r < 30) push_load($urandom_range(0, 15), vertex_raw(), vertex_raw());
        else push_aimed_test(MAX_VERTICES);
      end
      rand_words += n_words;
      drain();
      no_idle = 1'b0;
      ph++;
    end
    phases_run = ph;

    $display("covered %0d words (%0d box tests, %0d results checked) in %0d random phases",
             words_sent, tests_sent, verdicts_checked, phases_run);
    $display("zone registers written %0d times across all modes; %0d mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0 && due_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
